// File: rtl/tld_pkg.sv
// Shared types and constants for the tty line discipline block.
// No dependencies; imported by the top level and by its checker.
package tld_pkg;

  localparam int FILL_W = 9;  // width of the reported ring fill count
  localparam int CFG_W  = 9;  // widest configuration register
  localparam int CFG_IW = 3;  // configuration register index width

  // operations
  localparam logic [1:0] OP_RECV  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // result kinds
  localparam logic [2:0] K_TX    = 3'd0;
  localparam logic [2:0] K_RD    = 3'd1;
  localparam logic [2:0] K_EMPTY = 3'd2;
  localparam logic [2:0] K_NONE  = 3'd3;
  localparam logic [2:0] K_BLOCK = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] REG_INPUT_FLAGS  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_LOCAL_FLAGS  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_OUTPUT_FLAGS = 3'd2;
  localparam logic [CFG_IW-1:0] REG_START_CHAR   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_STOP_CHAR    = 3'd4;
  localparam logic [CFG_IW-1:0] REG_THROTTLE     = 3'd5;

  // characters
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CTL_FLIP = 8'h40;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic [1:0] tx_room;
    logic       batch_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [7:0]        out_byte;
    logic              stopped;
    logic              throttled;
    logic [FILL_W-1:0] fill_count;
    logic              last;
  } out_item_t;

  // up to two transmit bytes from output post-processing
  typedef struct packed {
    logic       ok;
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
  } tx_pair_t;

  // all results of one item plus the flags after it
  typedef struct packed {
    logic              two;
    logic [2:0]        k0;
    logic [7:0]        b0;
    logic [2:0]        k1;
    logic [7:0]        b1;
    logic              from_mem;
    logic              stopped;
    logic              throttled;
    logic [FILL_W-1:0] fill;
  } item_res_t;

endpackage

// File: rtl/tty_line_discipline_rx_tx.sv
// Top level of the tty line discipline: receive ring, echo and output processing.
// Depends on tld_pkg; the receive ring is a synchronous memory inside this module.
//
//  channel | ports                         | moves
//  --------+-------------------------------+------------------------------------
//  in      | in_valid / in_ready / in_data | one item: op, byte, tx room, batch end
//  out     | out_valid/out_ready/out_data  | one or two result items per in item
//  cfg     | cfg_we / cfg_index/ cfg_wdata | register write, no wait, no read-back
//
// An item is decoded in the cycle it is accepted: ring pointers, fill level and
// flags update at that edge, and the ring is written or read at the same edge.
// In the next cycle the item sits in a pending stage next to the registered ring
// read data, then moves to the output register. One result per cycle leaves
// while out_ready is high, so an item with two transmit bytes holds the output
// register until both have left; the output register sets the sustained rate.
// Reset (rst_n low, synchronous) empties both stages, pointers and flags and
// loads the register defaults; the ring contents are not cleared.
// A stalled output holds the output register; the pending stage still takes
// one more item before in_ready drops.
module tty_line_discipline_rx_tx
  import tld_pkg::*;
#(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam int PW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1; // ring index
  localparam int FW = PW + 1;                  // fill level, holds BUFFER_DEPTH
  localparam int CW = (FW > CFG_W) ? FW : CFG_W; // throttle compare width
  localparam logic [FW-1:0] DEPTH_F = FW'(BUFFER_DEPTH);
  localparam logic [PW-1:0] LAST_IDX = PW'(BUFFER_DEPTH - 1);

  // configuration
  logic [3:0] iflags_r;
  logic [1:0] lflags_r;
  logic [2:0] oflags_r;
  logic [7:0] start_r;
  logic [7:0] stop_r;
  logic [8:0] thresh_r;

  // block state
  logic [PW-1:0] rp_r, rp_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic          stopped_r, stopped_nxt;
  logic          throt_r, throt_nxt;

  // ring memory
  logic [7:0]    ring_mem [BUFFER_DEPTH];
  logic [7:0]    mem_q_r;
  logic          wr_en, rd_en;
  logic [PW-1:0] wr_addr;
  logic [PW:0]   wr_sum;
  logic [7:0]    wr_byte;

  // pipeline
  item_res_t res_nxt;
  logic      p_valid_r;
  item_res_t p_res_r;
  logic      r_valid_r;
  item_res_t r_res_r;
  logic      r_sel_r;
  logic      acc, r_done, r_free, p_move;

  // decode scratch
  logic [7:0] c2;
  logic       skip, ctl, full;
  logic [FW-1:0] free_room;
  tx_pair_t   tp;

  function automatic tx_pair_t post_out(input logic [7:0] c, input logic [1:0] room,
                                        input logic [2:0] of);
    tx_pair_t t;
    t = '0;
    if (room == 2'd0) begin
      t.ok = 1'b0;
    end else if (of[0] && c == CH_NL && of[2]) begin
      if (room[1]) begin
        t.ok  = 1'b1;
        t.two = 1'b1;
        t.b0  = CH_CR;
        t.b1  = CH_NL;
      end
    end else begin
      t.ok = 1'b1;
      t.b0 = (of[0] && of[1] && c == CH_CR) ? CH_NL : c;
    end
    return t;
  endfunction

  // ---------------------------------------------------------------- control
  assign r_done   = r_valid_r && out_ready && (r_sel_r || !r_res_r.two);
  assign r_free   = !r_valid_r || r_done;
  assign p_move   = p_valid_r && r_free;
  assign in_ready = !p_valid_r || p_move;
  assign acc      = in_valid && in_ready;

  // ---------------------------------------------------------------- decode
  always_comb begin
    res_nxt     = '0;
    res_nxt.k0  = K_NONE;
    res_nxt.k1  = K_NONE;
    rp_nxt      = rp_r;
    fill_nxt    = fill_r;
    stopped_nxt = stopped_r;
    throt_nxt   = throt_r;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    skip        = 1'b0;
    ctl         = 1'b0;
    c2          = in_data.data_byte;
    full        = (fill_r >= DEPTH_F);
    free_room   = '0;
    tp          = '0;
    wr_sum      = {1'b0, rp_r} + fill_r[PW:0];
    wr_addr     = (wr_sum >= (PW+1)'(BUFFER_DEPTH)) ?
                  PW'(wr_sum - (PW+1)'(BUFFER_DEPTH)) : wr_sum[PW-1:0];
    // at least one result: start as "nothing to send"
    case (in_data.operation)
      OP_RECV: begin
        if (iflags_r[0]) begin
          if (in_data.data_byte == start_r) begin
            stopped_nxt = 1'b0;
            skip = 1'b1;
          end else if (in_data.data_byte == stop_r) begin
            stopped_nxt = 1'b1;
            skip = 1'b1;
          end
        end
        if (!skip) begin
          if (in_data.data_byte == CH_CR) begin
            if (iflags_r[1]) skip = 1'b1;
            else if (iflags_r[2]) c2 = CH_NL;
          end else if (in_data.data_byte == CH_NL && iflags_r[3]) begin
            c2 = CH_CR;
          end
        end
        if (!skip) begin
          if (full) begin
            if (lflags_r[0]) begin
              res_nxt.k0 = K_TX;
              res_nxt.b0 = CH_BEL;
            end
          end else begin
            wr_en    = 1'b1;
            fill_nxt = fill_r + 1'b1;
            if (lflags_r[0]) begin
              ctl = (c2 < CH_SPACE || c2 == CH_DEL) && c2 != CH_TAB && c2 != CH_NL;
              if (lflags_r[1] && ctl) begin
                if (in_data.tx_room[1]) begin
                  res_nxt.two = 1'b1;
                  res_nxt.k0  = K_TX;
                  res_nxt.b0  = CH_CARET;
                  res_nxt.k1  = K_TX;
                  res_nxt.b1  = c2 ^ CTL_FLIP;
                end
              end else begin
                tp = post_out(c2, in_data.tx_room, oflags_r);
                if (tp.ok) begin
                  res_nxt.two = tp.two;
                  res_nxt.k0  = K_TX;
                  res_nxt.b0  = tp.b0;
                  res_nxt.k1  = tp.two ? K_TX : K_NONE;
                  res_nxt.b1  = tp.b1;
                end
              end
            end
          end
        end
        free_room = DEPTH_F - fill_nxt;
        if (in_data.batch_end && (CW'(free_room) < CW'(thresh_r))) throt_nxt = 1'b1;
      end
      OP_READ: begin
        if (fill_r == '0) begin
          res_nxt.k0 = K_EMPTY;
        end else begin
          rd_en            = 1'b1;
          res_nxt.k0       = K_RD;
          res_nxt.from_mem = 1'b1;
          rp_nxt           = (rp_r == LAST_IDX) ? '0 : rp_r + 1'b1;
          fill_nxt         = fill_r - 1'b1;
          free_room        = DEPTH_F - fill_nxt;
          if (CW'(free_room) >= CW'(thresh_r)) throt_nxt = 1'b0;
        end
      end
      OP_WRITE: begin
        if (oflags_r[0]) begin
          tp = post_out(in_data.data_byte, in_data.tx_room, oflags_r);
          if (tp.ok) begin
            res_nxt.two = tp.two;
            res_nxt.k0  = K_TX;
            res_nxt.b0  = tp.b0;
            res_nxt.k1  = tp.two ? K_TX : K_NONE;
            res_nxt.b1  = tp.b1;
          end else begin
            res_nxt.k0 = K_BLOCK;
          end
        end else if (in_data.tx_room != 2'd0) begin
          res_nxt.k0 = K_TX;
          res_nxt.b0 = in_data.data_byte;
        end else begin
          res_nxt.k0 = K_BLOCK;
        end
      end
      default: begin // clear ring
        fill_nxt = '0;
        rp_nxt   = '0;
      end
    endcase
    wr_byte           = c2;
    res_nxt.stopped   = stopped_nxt;
    res_nxt.throttled = throt_nxt;
    res_nxt.fill      = FILL_W'(fill_nxt);
  end

  // ---------------------------------------------------------------- ring
  always_ff @(posedge clk) begin
    if (acc && wr_en) ring_mem[wr_addr] <= wr_byte;
    if (acc && rd_en) mem_q_r <= ring_mem[rp_r];
  end

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iflags_r <= 4'd5;
      lflags_r <= 2'd3;
      oflags_r <= 3'd5;
      start_r  <= 8'd17;
      stop_r   <= 8'd19;
      thresh_r <= 9'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INPUT_FLAGS:  iflags_r <= cfg_wdata[3:0];
        REG_LOCAL_FLAGS:  lflags_r <= cfg_wdata[1:0];
        REG_OUTPUT_FLAGS: oflags_r <= cfg_wdata[2:0];
        REG_START_CHAR:   start_r  <= cfg_wdata[7:0];
        REG_STOP_CHAR:    stop_r   <= cfg_wdata[7:0];
        REG_THROTTLE:     thresh_r <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r      <= '0;
      fill_r    <= '0;
      stopped_r <= 1'b0;
      throt_r   <= 1'b0;
    end else if (acc) begin
      rp_r      <= rp_nxt;
      fill_r    <= fill_nxt;
      stopped_r <= stopped_nxt;
      throt_r   <= throt_nxt;
    end
  end

  // ---------------------------------------------------------------- stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      r_valid_r <= 1'b0;
      r_sel_r   <= 1'b0;
    end else begin
      p_valid_r <= acc || (p_valid_r && !p_move);
      if (p_move) begin
        r_valid_r <= 1'b1;
        r_sel_r   <= 1'b0;
      end else if (r_done) begin
        r_valid_r <= 1'b0;
      end else if (r_valid_r && out_ready) begin
        r_sel_r <= 1'b1;
      end
    end
  end

  // payload; read data joins the item as it leaves the pending stage
  always_ff @(posedge clk) begin
    if (acc) p_res_r <= res_nxt;
    if (p_move) begin
      r_res_r <= p_res_r;
      if (p_res_r.from_mem) r_res_r.b0 <= mem_q_r;
    end
  end

  assign out_valid           = r_valid_r;
  assign out_data.kind       = r_sel_r ? r_res_r.k1 : r_res_r.k0;
  assign out_data.out_byte   = r_sel_r ? r_res_r.b1 : r_res_r.b0;
  assign out_data.stopped    = r_res_r.stopped;
  assign out_data.throttled  = r_res_r.throttled;
  assign out_data.fill_count = r_res_r.fill;
  assign out_data.last       = r_sel_r || !r_res_r.two;

endmodule

// File: rtl/tld_checker.sv
// Port-level checker for tty_line_discipline_rx_tx, attached by bind.
// Depends on tld_pkg for the port types and result kinds.
module tld_checker
  import tld_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input in_item_t          in_data,
  input logic              out_valid,
  input logic              out_ready,
  input out_item_t         out_data,
  input logic              cfg_we,
  input logic [CFG_IW-1:0] cfg_index,
  input logic [CFG_W-1:0]  cfg_wdata
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.kind <= K_BLOCK)
    else $error("result kind out of range");

  // only transmit and read results carry a byte
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == K_EMPTY || out_data.kind == K_NONE ||
                  out_data.kind == K_BLOCK) |-> out_data.out_byte == 8'd0)
    else $error("byte on a result without data");

  // the first of two results is always a transmit byte
  a_first_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.kind == K_TX)
    else $error("non-transmit result followed by another");

  // the second of a pair follows with the same flags and fill
  a_pair_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last |=>
      out_valid && out_data.kind == K_TX && $stable(out_data.fill_count) &&
      $stable(out_data.stopped) && $stable(out_data.throttled))
    else $error("second result of a pair broken");

  wire unused_ok = ^{in_valid, in_ready, in_data, cfg_we, cfg_index, cfg_wdata};

endmodule

bind tty_line_discipline_rx_tx tld_checker u_tld_checker (.*);

// File: sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for tty_line_discipline_rx_tx: receive ring, echo, reads and writes.
// Depends on tld_pkg and the top level; mirrors the line discipline to predict each result.
module testbench;
  import tld_pkg::*;

  localparam int RING_DEPTH  = 256;   // matches the block's default BUFFER_DEPTH
  localparam int QUIET_LIMIT = 5000;  // cycles with no handshake before giving up

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_ready = 1'b1;
  out_item_t         out_data;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;

  tty_line_discipline_rx_tx u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Mirror of the line discipline: ring, pointers, flags and register copies.
  // ---------------------------------------------------------------------------
  logic [7:0] ring_copy [RING_DEPTH];
  int         ring_rd;
  int         ring_fill;
  logic       flag_stopped;
  logic       flag_throttled;

  logic [3:0] rx_iflag;
  logic [1:0] rx_lflag;
  logic [2:0] tx_oflag;
  logic [7:0] xon_char;
  logic [7:0] xoff_char;
  logic [8:0] thr_level;

  // results of the item being worked out, at most two
  logic [2:0] step_kind [2];
  logic [7:0] step_byte [2];
  int         step_n;

  out_item_t  line_results [$];  // results owed by the block, oldest first
  int         fail_count = 0;

  function automatic void stage_out(logic [2:0] k, logic [7:0] b);
    if (step_n < 2) begin
      step_kind[step_n] = k;
      step_byte[step_n] = b;
      step_n++;
    end
  endfunction

  // Output post-processing; returns 0 when the transmitter is short of room.
  function automatic bit oprocess(logic [7:0] c, int room);
    if (room < 1) return 1'b0;
    if (tx_oflag[0]) begin
      if (c == CH_CR) begin
        if (tx_oflag[1]) c = CH_NL;
      end else if (c == CH_NL && tx_oflag[2]) begin
        if (room < 2) return 1'b0;
        stage_out(K_TX, CH_CR);
      end
    end
    stage_out(K_TX, c);
    return 1'b1;
  endfunction

  // Works out what one accepted item makes the block send, and queues it.
  function automatic void run_discipline(in_item_t it);
    logic [7:0] c;
    int         room;
    bit         skip;
    bit         ctl;
    out_item_t  r;
    c      = it.data_byte;
    room   = int'(it.tx_room);   // three counts as "two or more"
    skip   = 1'b0;
    step_n = 0;
    case (it.operation)
      OP_RECV: begin
        if (rx_iflag[0]) begin
          // start wins when start and stop are the same character
          if (c == xon_char) begin
            flag_stopped = 1'b0;
            skip = 1'b1;
          end else if (c == xoff_char) begin
            flag_stopped = 1'b1;
            skip = 1'b1;
          end
        end
        if (!skip) begin
          if (c == CH_CR) begin
            if (rx_iflag[1]) skip = 1'b1;
            else if (rx_iflag[2]) c = CH_NL;
          end else if (c == CH_NL && rx_iflag[3]) begin
            c = CH_CR;
          end
        end
        if (!skip) begin
          if (ring_fill >= RING_DEPTH) begin
            // ring full: byte dropped, bell goes out whatever the room
            if (rx_lflag[0]) stage_out(K_TX, CH_BEL);
          end else begin
            ring_copy[(ring_rd + ring_fill) % RING_DEPTH] = c;
            ring_fill++;
            if (rx_lflag[0]) begin
              ctl = (c < CH_SPACE || c == CH_DEL) && c != CH_TAB && c != CH_NL;
              if (rx_lflag[1] && ctl) begin
                if (room >= 2) begin
                  stage_out(K_TX, CH_CARET);
                  stage_out(K_TX, c ^ CTL_FLIP);
                end
              end else begin
                void'(oprocess(c, room));
              end
            end
          end
        end
        // throttle check happens on every batch end, consumed byte or not
        if (it.batch_end && (RING_DEPTH - ring_fill) < int'(thr_level))
          flag_throttled = 1'b1;
      end
      OP_READ: begin
        if (ring_fill == 0) begin
          stage_out(K_EMPTY, 8'h00);
        end else begin
          stage_out(K_RD, ring_copy[ring_rd]);
          ring_rd = (ring_rd + 1) % RING_DEPTH;
          ring_fill--;
          if ((RING_DEPTH - ring_fill) >= int'(thr_level)) flag_throttled = 1'b0;
        end
      end
      OP_WRITE: begin
        if (tx_oflag[0]) begin
          if (!oprocess(c, room)) stage_out(K_BLOCK, 8'h00);
        end else if (room >= 1) begin
          stage_out(K_TX, c);
        end else begin
          stage_out(K_BLOCK, 8'h00);
        end
      end
      default: begin
        ring_fill = 0;
        ring_rd   = 0;
      end
    endcase
    if (step_n == 0) stage_out(K_NONE, 8'h00);
    for (int i = 0; i < step_n; i++) begin
      r.kind       = step_kind[i];
      r.out_byte   = step_byte[i];
      r.stopped    = flag_stopped;
      r.throttled  = flag_throttled;
      r.fill_count = ring_fill[FILL_W-1:0];
      r.last       = (i == step_n - 1);
      line_results.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest one owed.
  // ---------------------------------------------------------------------------
  out_item_t got_want;

  function automatic void check_field(string fname, logic [8:0] want, logic [8:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (line_results.size() == 0) begin
        $error("result with none outstanding: kind %0d byte %0h",
               out_data.kind, out_data.out_byte);
        fail_count++;
      end else begin
        got_want = line_results.pop_front();
        check_field("kind",       9'(got_want.kind),       9'(out_data.kind));
        check_field("out_byte",   9'(got_want.out_byte),   9'(out_data.out_byte));
        check_field("stopped",    9'(got_want.stopped),    9'(out_data.stopped));
        check_field("throttled",  9'(got_want.throttled),  9'(out_data.throttled));
        check_field("fill_count", 9'(got_want.fill_count), 9'(out_data.fill_count));
        check_field("last",       9'(got_want.last),       9'(out_data.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: windows of differing stall styles, plus a long hold on request.
  // ---------------------------------------------------------------------------
  bit stall_request;   // toggled by the tests to ask for a long hold
  bit stall_ack;
  int hold_left;
  int win_left;
  int win_style;

  always @(posedge clk) begin
    if (stall_request != stall_ack) begin
      hold_left = 150;
      stall_ack = stall_request;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (win_left == 0) begin
        win_style = $urandom_range(0, 3);
        win_left  = $urandom_range(16, 80);
      end
      win_left--;
      case (win_style)
        0:       out_ready <= 1'b1;                       // no stalls
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 3) == 0); // mostly stalled
        default: out_ready <= ~out_ready;
      endcase
    end
  end

  // Watchdog: too long without any item moving on either channel.
  int quiet_cycles;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tty_line_discipline_rx_tx verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  bit gaps_on;
  int burst_left;

  function automatic in_item_t mk(logic [1:0] op, logic [7:0] b, logic [1:0] room,
                                  logic be);
    in_item_t it;
    it.operation = op;
    it.data_byte = b;
    it.tx_room   = room;
    it.batch_end = be;
    return it;
  endfunction

  // Offer one item, wait for the handshake, then maybe end the burst with a gap.
  task automatic send_item(in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    run_discipline(it);
    if (gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(0, 12);
      end
    end
  endtask

  // Stop offering and wait until everything owed has come back.
  task automatic settle_line();
    in_valid <= 1'b0;
    do @(posedge clk); while (line_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Register write; only called with the block idle.
  task automatic set_reg(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_INPUT_FLAGS:  rx_iflag  = val[3:0];
      REG_LOCAL_FLAGS:  rx_lflag  = val[1:0];
      REG_OUTPUT_FLAGS: tx_oflag  = val[2:0];
      REG_START_CHAR:   xon_char  = val[7:0];
      REG_STOP_CHAR:    xoff_char = val[7:0];
      REG_THROTTLE:     thr_level = val[8:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Bytes that hit the special paths more often than a flat draw would.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 19))
      0:       return CH_CR;
      1:       return CH_NL;
      2:       return CH_TAB;
      3:       return CH_DEL;
      4:       return xon_char;
      5:       return xoff_char;
      6:       return 8'($urandom_range(0, 31));
      7:       return 8'hFF;
      8:       return CH_SPACE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset defaults: xon/xoff on, CR to NL, caret echo, NL to CR NL on output.
  task automatic test_default_paths();
    gaps_on = 1'b1;
    send_item(mk(OP_RECV,  "A",     2'd2, 1'b0));
    send_item(mk(OP_RECV,  8'h00,   2'd2, 1'b0));  // ^@
    send_item(mk(OP_RECV,  CH_DEL,  2'd3, 1'b0));  // ^?, room three acts as two
    send_item(mk(OP_RECV,  8'h01,   2'd1, 1'b0));  // caret echo short of room
    send_item(mk(OP_RECV,  CH_TAB,  2'd0, 1'b0));  // plain echo short of room
    send_item(mk(OP_RECV,  CH_NL,   2'd1, 1'b0));  // CR NL echo short of room
    send_item(mk(OP_RECV,  CH_NL,   2'd2, 1'b0));
    send_item(mk(OP_RECV,  CH_CR,   2'd2, 1'b0));  // stored as NL
    send_item(mk(OP_RECV,  8'hFF,   2'd2, 1'b1));
    send_item(mk(OP_RECV,  8'd19,   2'd2, 1'b0));  // stop
    send_item(mk(OP_RECV,  8'd17,   2'd0, 1'b1));  // start, batch end still checked
    send_item(mk(OP_WRITE, CH_NL,   2'd1, 1'b0));  // blocked
    send_item(mk(OP_WRITE, CH_NL,   2'd3, 1'b0));
    send_item(mk(OP_WRITE, CH_CR,   2'd2, 1'b0));
    send_item(mk(OP_WRITE, 8'h55,   2'd0, 1'b0));  // blocked
    send_item(mk(OP_WRITE, 8'h00,   2'd1, 1'b1));
    send_item(mk(OP_READ,  8'hAA,   2'd3, 1'b1));
    send_item(mk(OP_READ,  8'h00,   2'd0, 1'b0));
    send_item(mk(OP_READ,  8'h00,   2'd0, 1'b0));
    send_item(mk(OP_CLEAR, 8'hFF,   2'd3, 1'b1));
    send_item(mk(OP_READ,  8'h00,   2'd0, 1'b0));  // empty
    settle_line();
  endtask

  // Flag settings one at a time, including start equal to stop.
  task automatic test_flag_settings();
    send_item(mk(OP_RECV, 8'd19, 2'd2, 1'b0));     // stopped
    settle_line();
    set_reg(REG_INPUT_FLAGS, 9'hF);
    set_reg(REG_START_CHAR,  9'h55);
    set_reg(REG_STOP_CHAR,   9'h55);
    send_item(mk(OP_RECV, 8'h55, 2'd2, 1'b0));     // start wins
    send_item(mk(OP_RECV, CH_CR, 2'd2, 1'b0));     // ignored
    send_item(mk(OP_RECV, CH_NL, 2'd2, 1'b0));     // stored as CR, ^M
    settle_line();
    set_reg(REG_INPUT_FLAGS,  9'h0);
    set_reg(REG_LOCAL_FLAGS,  9'h1);
    set_reg(REG_OUTPUT_FLAGS, 9'h7);
    set_reg(REG_THROTTLE,     9'd256);
    send_item(mk(OP_RECV,  8'h01, 2'd1, 1'b0));    // no caret, raw echo
    send_item(mk(OP_RECV,  CH_CR, 2'd2, 1'b1));    // echoed as NL, throttled
    send_item(mk(OP_WRITE, CH_CR, 2'd1, 1'b0));
    send_item(mk(OP_READ,  8'h00, 2'd0, 1'b0));
    settle_line();
    set_reg(REG_LOCAL_FLAGS,  9'h0);
    set_reg(REG_OUTPUT_FLAGS, 9'h0);
    set_reg(REG_THROTTLE,     9'd0);
    set_reg(REG_INPUT_FLAGS,  9'h1);
    set_reg(REG_START_CHAR,   9'h00);
    set_reg(REG_STOP_CHAR,    9'hFF);
    send_item(mk(OP_RECV,  8'hFF, 2'd2, 1'b1));    // stop at the top extreme
    send_item(mk(OP_RECV,  "x",   2'd2, 1'b1));    // no echo
    send_item(mk(OP_WRITE, CH_NL, 2'd1, 1'b0));    // raw
    send_item(mk(OP_WRITE, "a",   2'd0, 1'b0));    // blocked
    send_item(mk(OP_RECV,  8'h00, 2'd0, 1'b0));    // start at the bottom extreme
    settle_line();
  endtask

  // Fill the ring to the brim, overflow it, then read part of it back; the rest
  // stays in the ring so later receives wrap the write index.
  task automatic test_ring_overflow();
    set_reg(REG_INPUT_FLAGS, 9'hC);                // no byte is consumed
    set_reg(REG_LOCAL_FLAGS, 9'h3);
    set_reg(REG_THROTTLE,    CFG_W'($urandom_range(1, 256)));
    send_item(mk(OP_CLEAR, 8'h00, 2'd0, 1'b0));
    while (ring_fill < RING_DEPTH)
      send_item(mk(OP_RECV, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                   ($urandom_range(0, 7) == 0)));
    send_item(mk(OP_RECV, 8'h41, 2'd0, 1'b0));     // bell despite no room
    send_item(mk(OP_RECV, CH_NL, 2'd2, 1'b1));
    settle_line();
    set_reg(REG_LOCAL_FLAGS, 9'h0);
    send_item(mk(OP_RECV, 8'h42, 2'd2, 1'b1));     // full and silent
    repeat (32)
      send_item(mk(OP_READ, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                   1'($urandom_range(0, 1))));
    settle_line();
  endtask

  // Receiver holds off while the sender keeps offering, so the input backs up.
  task automatic test_output_backpressure();
    set_reg(REG_LOCAL_FLAGS,  9'h3);
    set_reg(REG_OUTPUT_FLAGS, 9'h5);
    gaps_on       = 1'b0;
    stall_request = ~stall_request;
    repeat (40)
      send_item(mk(2'($urandom_range(0, 2)), pick_byte(), 2'($urandom_range(0, 3)),
                   1'($urandom_range(0, 1))));
    gaps_on = 1'b1;
    settle_line();
  endtask

  // Random traffic under a series of settings, the extremes first.
  task automatic test_random_traffic();
    int sel;
    int read_pct;
    for (int ph = 0; ph < 6; ph++) begin
      settle_line();
      case (ph)
        0: begin
          set_reg(REG_INPUT_FLAGS, 9'hF);  set_reg(REG_LOCAL_FLAGS, 9'h3);
          set_reg(REG_OUTPUT_FLAGS, 9'h7); set_reg(REG_START_CHAR, 9'h00);
          set_reg(REG_STOP_CHAR, 9'hFF);   set_reg(REG_THROTTLE, 9'd256);
        end
        1: begin
          set_reg(REG_INPUT_FLAGS, 9'h0);  set_reg(REG_LOCAL_FLAGS, 9'h0);
          set_reg(REG_OUTPUT_FLAGS, 9'h0); set_reg(REG_START_CHAR, 9'hFF);
          set_reg(REG_STOP_CHAR, 9'h00);   set_reg(REG_THROTTLE, 9'd0);
        end
        default: begin
          set_reg(REG_INPUT_FLAGS,  CFG_W'($urandom_range(0, 15)));
          set_reg(REG_LOCAL_FLAGS,  CFG_W'($urandom_range(0, 3)));
          set_reg(REG_OUTPUT_FLAGS, CFG_W'($urandom_range(0, 7)));
          set_reg(REG_START_CHAR,   CFG_W'($urandom_range(0, 255)));
          // now and then start and stop collide
          set_reg(REG_STOP_CHAR, CFG_W'(($urandom_range(0, 3) == 0) ? xon_char
                                                      : $urandom_range(0, 255)));
          set_reg(REG_THROTTLE,     CFG_W'($urandom_range(0, 256)));
        end
      endcase
      gaps_on  = (ph != 3);                      // one phase runs flat out
      read_pct = (ph == 4) ? 10 : 30;            // let the ring grow in one phase
      repeat (25) begin
        sel = $urandom_range(0, 99);
        if (sel < 55)
          send_item(mk(OP_RECV, pick_byte(), 2'($urandom_range(0, 3)),
                       1'($urandom_range(0, 1))));
        else if (sel < 55 + read_pct)
          send_item(mk(OP_READ, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                       1'($urandom_range(0, 1))));
        else if (sel < 97)
          send_item(mk(OP_WRITE, pick_byte(), 2'($urandom_range(0, 3)),
                       1'($urandom_range(0, 1))));
        else
          send_item(mk(OP_CLEAR, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                       1'($urandom_range(0, 1))));
      end
    end
    settle_line();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    ring_rd        = 0;
    ring_fill      = 0;
    flag_stopped   = 1'b0;
    flag_throttled = 1'b0;
    rx_iflag  = 4'd5;
    rx_lflag  = 2'd3;
    tx_oflag  = 3'd5;
    xon_char  = 8'd17;
    xoff_char = 8'd19;
    thr_level = 9'd64;
    burst_left = 0;
    gaps_on    = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_paths();
    test_flag_settings();
    test_ring_overflow();
    test_output_backpressure();
    test_random_traffic();

    repeat (20) @(posedge clk);
    if (fail_count == 0 && line_results.size() == 0) begin
      $display("tty_line_discipline_rx_tx verification clean");
    end else begin
      $display("tty_line_discipline_rx_tx verification failed");
    end
    $finish;
  end

endmodule
